FILE: sv/ghalloc_pkg.sv
// ---------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and codes for the generational handle allocator.
// ---------------------------------------------------------------------------
package ghalloc_pkg;

  // default table depth
  localparam int MAX_SLOTS_DEF = 1024;

  // fixed field widths
  localparam int REQ_W = 2;
  localparam int ST_W  = 2;
  localparam int GEN_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_STALE = 2'd2;

  // generation given to a slot on its first use
  localparam logic [GEN_W-1:0] FIRST_GEN = 32'd1;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FRESH,
    OP_FULL,
    OP_TBL_RD,
    OP_POP,
    OP_REUSE,
    OP_KILL,
    OP_LIVE,
    OP_STALE
  } dp_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             stk_empty;
    logic             hw_full;
    logic             idx_ok;
    logic             hit;
    logic             fd_full;
  } dp_status_t;

endpackage

FILE: sv/generational_handle_allocator.sv
// ---------------------------------------------------------------------------
// generational_handle_allocator
// Hands out, retires and checks handles made of a slot index and generation.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its one result word
// appears with done high for a single cycle and cannot be held off, so the
// receiver must take it then. After the start cycle a request passes a decode
// state before done (create from a never-used slot, full table, or
// out-of-range handle); destroy and check also pass a look state that reads
// the slot table, and a create that pops a freed slot passes pop and reuse
// states, as each read of the stack or table RAM is registered; busy falls
// with done, so the next request may start in that cycle. No clearing pass
// is needed after reset: slots at or above the high-water mark read as dead.
module generational_handle_allocator #(
  parameter int MAX_SLOTS = ghalloc_pkg::MAX_SLOTS_DEF,
  localparam int IW = $clog2(MAX_SLOTS),
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ghalloc_pkg::REQ_W-1:0] req_type,
  input  logic [IW-1:0]                 handle_index,
  input  logic [ghalloc_pkg::GEN_W-1:0] handle_generation,
  output logic                          done,
  output logic [ghalloc_pkg::ST_W-1:0]  status,
  output logic [IW-1:0]                 new_index,
  output logic [ghalloc_pkg::GEN_W-1:0] new_generation,
  output logic [CW-1:0]                 live_total
);

  ghalloc_pkg::dp_op_t     op;
  ghalloc_pkg::dp_status_t stat;

  // request sequencing
  ghalloc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .op    (op)
  );

  // tables, counters and result word
  ghalloc_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .stat              (stat),
    .req_type          (req_type),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .done              (done),
    .status            (status),
    .new_index         (new_index),
    .new_generation    (new_generation),
    .live_total        (live_total)
  );

endmodule

FILE: sv/ghalloc_ram.sv
// ---------------------------------------------------------------------------
// ghalloc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ghalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ghalloc_dp.sv
// ---------------------------------------------------------------------------
// ghalloc_dp
// Datapath: request registers, counters, slot table, free stack, result word.
// ---------------------------------------------------------------------------
module ghalloc_dp #(
  parameter int MAX_SLOTS = ghalloc_pkg::MAX_SLOTS_DEF,
  localparam int IW = $clog2(MAX_SLOTS),
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ghalloc_pkg::dp_op_t           op,
  output ghalloc_pkg::dp_status_t       stat,
  input  logic [ghalloc_pkg::REQ_W-1:0] req_type,
  input  logic [IW-1:0]                 handle_index,
  input  logic [ghalloc_pkg::GEN_W-1:0] handle_generation,
  output logic                          done,
  output logic [ghalloc_pkg::ST_W-1:0]  status,
  output logic [IW-1:0]                 new_index,
  output logic [ghalloc_pkg::GEN_W-1:0] new_generation,
  output logic [CW-1:0]                 live_total
);

  localparam int TW = ghalloc_pkg::GEN_W + 1;

  // request word
  logic [ghalloc_pkg::REQ_W-1:0] req_q;
  logic [IW-1:0]                 idx_q;
  logic [ghalloc_pkg::GEN_W-1:0] gen_q;
  logic [IW-1:0]                 slot_q;

  // bookkeeping counters
  logic [CW-1:0] free_depth;
  logic [CW-1:0] high_water;
  logic [CW-1:0] live_count;
  logic [CW-1:0] live_next;

  // memory ports
  logic                          tbl_we;
  logic [IW-1:0]                 tbl_waddr;
  logic [TW-1:0]                 tbl_wdata;
  logic [IW-1:0]                 tbl_raddr;
  logic [TW-1:0]                 tbl_rdata;
  logic [ghalloc_pkg::GEN_W-1:0] tbl_gen;
  logic                          tbl_alive;
  logic                          stk_we;
  logic [IW-1:0]                 stk_raddr;
  logic [IW-1:0]                 stk_rdata;

  assign tbl_gen   = tbl_rdata[ghalloc_pkg::GEN_W-1:0];
  assign tbl_alive = tbl_rdata[ghalloc_pkg::GEN_W];

  // status for the controller; slots at or above the high-water mark are dead
  always_comb begin
    stat.req       = req_q;
    stat.stk_empty = (free_depth == '0);
    stat.hw_full   = (high_water == CW'(MAX_SLOTS));
    stat.idx_ok    = (CW'(idx_q) < high_water);
    stat.hit       = tbl_alive && (tbl_gen == gen_q);
    stat.fd_full   = (free_depth == CW'(MAX_SLOTS));
  end

  // table access: look up the handle or the popped slot, and write fresh, reused or killed entries
  always_comb begin
    tbl_raddr = (op == ghalloc_pkg::OP_TBL_RD) ? idx_q : stk_rdata;
    tbl_we    = 1'b0;
    tbl_waddr = idx_q;
    tbl_wdata = {1'b0, gen_q + ghalloc_pkg::FIRST_GEN};
    unique case (op)
      ghalloc_pkg::OP_FRESH: begin
        tbl_we    = 1'b1;
        tbl_waddr = high_water[IW-1:0];
        tbl_wdata = {1'b1, ghalloc_pkg::FIRST_GEN};
      end
      ghalloc_pkg::OP_REUSE: begin
        tbl_we    = 1'b1;
        tbl_waddr = slot_q;
        tbl_wdata = {1'b1, tbl_gen};
      end
      ghalloc_pkg::OP_KILL: begin
        tbl_we    = 1'b1;
        tbl_wdata = {1'b0, gen_q + ghalloc_pkg::FIRST_GEN};
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // stack top is always being read; push on destroy
  assign stk_raddr = IW'(free_depth - CW'(1));
  assign stk_we    = (op == ghalloc_pkg::OP_KILL);

  // live count after this request
  always_comb begin
    unique case (op)
      ghalloc_pkg::OP_FRESH,
      ghalloc_pkg::OP_REUSE: live_next = live_count + CW'(1);
      ghalloc_pkg::OP_KILL:  live_next = live_count - CW'(1);
      default:               live_next = live_count;
    endcase
  end

  ghalloc_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_SLOTS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ghalloc_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_SLOTS)
  ) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_depth[IW-1:0]),
    .wdata (idx_q),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (op == ghalloc_pkg::OP_LOAD) begin
      req_q <= req_type;
      idx_q <= handle_index;
      gen_q <= handle_generation;
    end
    if (op == ghalloc_pkg::OP_POP) begin
      slot_q <= stk_rdata;
    end
  end

  // counters and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      high_water <= '0;
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      live_count <= live_next;
      done       <= 1'b0;
      unique case (op)
        ghalloc_pkg::OP_POP:   free_depth <= free_depth - CW'(1);
        ghalloc_pkg::OP_KILL:  free_depth <= free_depth + CW'(1);
        ghalloc_pkg::OP_FRESH: high_water <= high_water + CW'(1);
        default: ;
      endcase
      unique case (op)
        ghalloc_pkg::OP_FRESH,
        ghalloc_pkg::OP_REUSE,
        ghalloc_pkg::OP_FULL,
        ghalloc_pkg::OP_KILL,
        ghalloc_pkg::OP_LIVE,
        ghalloc_pkg::OP_STALE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    live_total <= live_next;
    unique case (op)
      ghalloc_pkg::OP_FRESH: begin
        status         <= ghalloc_pkg::ST_OK;
        new_index      <= high_water[IW-1:0];
        new_generation <= ghalloc_pkg::FIRST_GEN;
      end
      ghalloc_pkg::OP_REUSE: begin
        status         <= ghalloc_pkg::ST_OK;
        new_index      <= slot_q;
        new_generation <= tbl_gen;
      end
      ghalloc_pkg::OP_FULL: begin
        status         <= ghalloc_pkg::ST_FULL;
        new_index      <= '0;
        new_generation <= '0;
      end
      ghalloc_pkg::OP_KILL,
      ghalloc_pkg::OP_LIVE: begin
        status         <= ghalloc_pkg::ST_OK;
        new_index      <= '0;
        new_generation <= '0;
      end
      ghalloc_pkg::OP_STALE: begin
        status         <= ghalloc_pkg::ST_STALE;
        new_index      <= '0;
        new_generation <= '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/ghalloc_ctrl.sv
// ---------------------------------------------------------------------------
// ghalloc_ctrl
// Controller: sequences each request through decode, stack pop and lookup.
// ---------------------------------------------------------------------------
module ghalloc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  ghalloc_pkg::dp_status_t stat,
  output ghalloc_pkg::dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_REUSE,
    S_LOOK
  } state_t;

  state_t state;
  state_t state_next;

  // next state and datapath command
  always_comb begin
    state_next = state;
    op         = ghalloc_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op         = ghalloc_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.req)
          ghalloc_pkg::REQ_CREATE: begin
            // stack top read is already under way
            if (!stat.stk_empty) begin
              state_next = S_POP;
            end else if (!stat.hw_full) begin
              op = ghalloc_pkg::OP_FRESH;
            end else begin
              op = ghalloc_pkg::OP_FULL;
            end
          end
          ghalloc_pkg::REQ_DESTROY,
          ghalloc_pkg::REQ_CHECK: begin
            if (stat.idx_ok) begin
              op         = ghalloc_pkg::OP_TBL_RD;
              state_next = S_LOOK;
            end else begin
              op = ghalloc_pkg::OP_STALE;
            end
          end
          default: begin
            op = ghalloc_pkg::OP_STALE;
          end
        endcase
      end
      S_POP: begin
        op         = ghalloc_pkg::OP_POP;
        state_next = S_REUSE;
      end
      S_REUSE: begin
        op         = ghalloc_pkg::OP_REUSE;
        state_next = S_IDLE;
      end
      S_LOOK: begin
        state_next = S_IDLE;
        if (!stat.hit) begin
          op = ghalloc_pkg::OP_STALE;
        end else if (stat.req == ghalloc_pkg::REQ_CHECK) begin
          op = ghalloc_pkg::OP_LIVE;
        end else if (!stat.fd_full) begin
          op = ghalloc_pkg::OP_KILL;
        end else begin
          op = ghalloc_pkg::OP_STALE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

FILE: sv/ghalloc_checker.sv
// ---------------------------------------------------------------------------
// ghalloc_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
module ghalloc_checker #(
  parameter int MAX_SLOTS = ghalloc_pkg::MAX_SLOTS_DEF,
  localparam int IW = $clog2(MAX_SLOTS),
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [ghalloc_pkg::ST_W-1:0]  status,
  input logic [IW-1:0]                 new_index,
  input logic [ghalloc_pkg::GEN_W-1:0] new_generation,
  input logic [CW-1:0]                 live_total
);

  // an accepted word keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  // a result word ends the request
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result word");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ghalloc_pkg::ST_OK || status == ghalloc_pkg::ST_FULL ||
              status == ghalloc_pkg::ST_STALE))
    else $error("undefined status code");

  // only a successful create carries a handle
  a_no_handle_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && status != ghalloc_pkg::ST_OK |-> new_index == '0 && new_generation == '0)
    else $error("handle fields set on failed request");

  // live count never exceeds the table
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> live_total <= CW'(MAX_SLOTS))
    else $error("live count beyond table size");

endmodule

bind generational_handle_allocator ghalloc_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_ghalloc_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .new_index      (new_index),
  .new_generation (new_generation),
  .live_total     (live_total)
);
